FILE: rtl/core/bitmap_font_text_rasterizer_macros.svh
// assertion macros shared by the rasteriser rtl
// needs nothing but a clock and a synchronous reset at the point of use
`ifndef BITMAP_FONT_TEXT_RASTERIZER_MACROS_SVH
`define BITMAP_FONT_TEXT_RASTERIZER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BFT_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("bft assertion failed in same cycle");

// consequent must hold in the cycle after the antecedent
`define BFT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("bft assertion failed in next cycle");

`endif

FILE: rtl/core/bft_pkg.sv
// shared types, constants and the 5x7 font rom for the text rasteriser
// no dependencies
package bft_pkg;

  localparam int XW     = 18;
  localparam int YW     = 17;
  localparam int SCALEW = 6;
  localparam int GLYPHW = 35;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // register indexes, byte address is four times the index
  localparam logic [1:0] REG_TEXT_SIZE   = 2'd0;
  localparam logic [1:0] REG_CENTER_MODE = 2'd1;
  localparam logic [1:0] REG_INK_COLOR   = 2'd2;

  typedef struct packed {
    logic [SCALEW-1:0] scale;
    logic              center;
    logic [31:0]       color;
  } cfg_t;

  typedef struct packed {
    logic [XW-1:0] a;
    logic [XW-1:0] b;
    logic          sub;
  } alu_req_t;

  // scale = max(1, size / 7), reciprocal 293/2048 is exact over 0..255
  function automatic logic [SCALEW-1:0] scale_of(input logic [7:0] size);
    logic [16:0] prod;
    logic [SCALEW-1:0] q;
    prod = {9'd0, size} * 17'd293;
    q = prod[16:11];
    if (q == '0) begin
      q = SCALEW'(1);
    end
    return q;
  endfunction

  function automatic logic [GLYPHW-1:0] rows7(input logic [4:0] r0, input logic [4:0] r1,
                                              input logic [4:0] r2, input logic [4:0] r3,
                                              input logic [4:0] r4, input logic [4:0] r5,
                                              input logic [4:0] r6);
    return {r0, r1, r2, r3, r4, r5, r6};
  endfunction

  // top row in the high bits, leftmost pixel as msb of each row
  function automatic logic [GLYPHW-1:0] font_lookup(input logic [7:0] code);
    logic [7:0] c;
    logic [GLYPHW-1:0] g;
    c = code;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      c = c - CH_LOWER_A + CH_UPPER_A;
    end
    case (c)
      8'h30: g = rows7(5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E);
      8'h31: g = rows7(5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
      8'h32: g = rows7(5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F);
      8'h33: g = rows7(5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E);
      8'h34: g = rows7(5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02);
      8'h35: g = rows7(5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E);
      8'h36: g = rows7(5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E);
      8'h37: g = rows7(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08);
      8'h38: g = rows7(5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E);
      8'h39: g = rows7(5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C);
      8'h41: g = rows7(5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
      8'h42: g = rows7(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E);
      8'h43: g = rows7(5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E);
      8'h44: g = rows7(5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E);
      8'h45: g = rows7(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F);
      8'h46: g = rows7(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10);
      8'h47: g = rows7(5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E);
      8'h48: g = rows7(5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
      8'h49: g = rows7(5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
      8'h4A: g = rows7(5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C);
      8'h4B: g = rows7(5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11);
      8'h4C: g = rows7(5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F);
      8'h4D: g = rows7(5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11);
      8'h4E: g = rows7(5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11);
      8'h4F: g = rows7(5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
      8'h50: g = rows7(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10);
      8'h51: g = rows7(5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D);
      8'h52: g = rows7(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11);
      8'h53: g = rows7(5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E);
      8'h54: g = rows7(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04);
      8'h55: g = rows7(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
      8'h56: g = rows7(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04);
      8'h57: g = rows7(5'h11, 5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A);
      8'h58: g = rows7(5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11);
      8'h59: g = rows7(5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04);
      8'h5A: g = rows7(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F);
      8'h2D: g = rows7(5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00);
      8'h3A: g = rows7(5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00);
      8'h2E: g = rows7(5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C);
      8'h21: g = rows7(5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04);
      8'h2B: g = rows7(5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00);
      8'h3E: g = rows7(5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10);
      8'h3C: g = rows7(5'h01, 5'h02, 5'h04, 5'h08, 5'h04, 5'h02, 5'h01);
      8'h2F: g = rows7(5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00);
      8'h2C: g = rows7(5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h04, 5'h08);
      8'h28: g = rows7(5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02);
      8'h29: g = rows7(5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08);
      // space and unknown codes draw nothing but still advance
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/core/bft_alu.sv
// shared 18-bit add/subtract unit used for every coordinate update
// depends on bft_pkg
module bft_alu (
  input  bft_pkg::alu_req_t        req,
  output logic [bft_pkg::XW-1:0]   sum
);
  import bft_pkg::*;

  assign sum = req.a + (req.sub ? ~req.b : req.b) + {{(XW-1){1'b0}}, req.sub};

endmodule

FILE: rtl/core/bft_regs.sv
// apb configuration registers: text size (held raw and as derived scale), centre mode, ink colour
// depends on bft_pkg
module bft_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output bft_pkg::cfg_t     cfg
);
  import bft_pkg::*;

  logic [7:0]  text_size;
  logic        center_mode;
  logic [31:0] ink_color;
  logic [SCALEW-1:0] scale;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_size   <= 8'd7;
      center_mode <= 1'b0;
      ink_color   <= 32'hFFFF_FFFF;
      scale       <= SCALEW'(1);
    end else if (wr) begin
      case (paddr[3:2])
        REG_TEXT_SIZE: begin
          text_size <= pwdata[7:0];
          scale     <= scale_of(pwdata[7:0]);
        end
        REG_CENTER_MODE: center_mode <= pwdata[0];
        REG_INK_COLOR:   ink_color   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TEXT_SIZE:   prdata = {24'd0, text_size};
      REG_CENTER_MODE: prdata = {31'd0, center_mode};
      REG_INK_COLOR:   prdata = ink_color;
      default:         prdata = '0;
    endcase
  end

  assign cfg.scale  = scale;
  assign cfg.center = center_mode;
  assign cfg.color  = ink_color;

endmodule

FILE: rtl/core/bft_seq.sv
// sequencer: origin latch, glyph bit scan, cursor advance and the output register
// depends on bft_pkg, bft_alu (through the top level) and the assertion macros
`include "bitmap_font_text_rasterizer_macros.svh"
module bft_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  bft_pkg::cfg_t            cfg,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [47:0]              s_tdata,
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [79:0]              m_tdata,
  output logic                     m_tlast,
  output bft_pkg::alu_req_t        alu_req,
  input  logic [bft_pkg::XW-1:0]   alu_sum
);
  import bft_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ORIGIN = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_ADV    = 5'b10000
  } state_t;

  state_t state;

  // per-item registers
  logic              first;
  logic [15:0]       ox;
  logic [15:0]       oy;
  logic              len_zero;
  logic [15:0]       total;
  logic [SCALEW-1:0] scale;
  logic [7:0]        step6;
  logic [GLYPHW-1:0] glyph_sr;
  logic [2:0]        col;
  logic [XW-1:0]     xacc;
  logic [YW-1:0]     yacc;

  // string state
  logic [XW-1:0]     cursor_x;
  logic [15:0]       text_top;

  // output register
  logic [XW-1:0]     rect_x;
  logic [YW-1:0]     rect_y;
  logic [SCALEW-1:0] rect_size;
  logic [31:0]       rect_color;

  logic        accept;
  logic        stall;
  logic        out_load;
  logic        rest_zero;
  logic [10:0] len6m1;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign stall     = glyph_sr[GLYPHW-1] && m_tvalid && !m_tready;
  assign out_load  = (state == ST_SCAN) && glyph_sr[GLYPHW-1] && !stall;
  assign rest_zero = (glyph_sr[GLYPHW-2:0] == '0);
  assign len6m1    = {1'b0, s_tdata[47:40], 2'b00} + {2'b00, s_tdata[47:40], 1'b0} - 11'd1;

  always_comb begin
    case (state)
      ST_ORIGIN: begin
        alu_req.a   = {{(XW-16){ox[15]}}, ox};
        // total/2 truncates toward zero, so an empty string adds half a scale
        if (!cfg.center) begin
          alu_req.b = '0;
        end else if (len_zero) begin
          alu_req.b = XW'(scale >> 1);
        end else begin
          alu_req.b = XW'(total >> 1);
        end
        alu_req.sub = cfg.center && !len_zero;
      end
      ST_SCAN: begin
        alu_req.a   = (col == 3'd4) ? {yacc[YW-1], yacc} : xacc;
        alu_req.b   = XW'(scale);
        alu_req.sub = 1'b0;
      end
      ST_ADV: begin
        alu_req.a   = cursor_x;
        alu_req.b   = XW'(step6);
        alu_req.sub = 1'b0;
      end
      default: begin
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cursor_x <= '0;
      text_top <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_ORIGIN;
          end
        end
        ST_ORIGIN: begin
          if (first) begin
            cursor_x <= alu_sum;
            text_top <= oy;
          end
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= (glyph_sr == '0) ? ST_ADV : ST_SCAN;
        end
        ST_SCAN: begin
          if (!stall && rest_zero) begin
            state <= ST_ADV;
          end
        end
        ST_ADV: begin
          cursor_x <= alu_sum;
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      first    <= s_tuser;
      ox       <= s_tdata[23:8];
      oy       <= s_tdata[39:24];
      len_zero <= (s_tdata[47:40] == 8'd0);
      total    <= {5'd0, len6m1} * {10'd0, cfg.scale};
      scale    <= cfg.scale;
      step6    <= {cfg.scale, 2'b00} + {1'b0, cfg.scale, 1'b0};
      glyph_sr <= font_lookup(s_tdata[7:0]);
    end else if (state == ST_LOAD) begin
      xacc <= cursor_x;
      yacc <= {text_top[15], text_top};
      col  <= '0;
    end else if (state == ST_SCAN && !stall) begin
      glyph_sr <= glyph_sr << 1;
      if (col == 3'd4) begin
        col  <= '0;
        xacc <= cursor_x;
        yacc <= alu_sum[YW-1:0];
      end else begin
        col  <= col + 3'd1;
        xacc <= alu_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rect_x     <= xacc;
      rect_y     <= yacc;
      rect_size  <= scale;
      rect_color <= cfg.color;
      m_tlast    <= rest_zero;
    end
  end

  assign m_tdata = {7'd0, rect_color, rect_size, rect_y, rect_x};

  `BFT_ASSERT_NEXT(a_accept_origin, clk, rst, accept, state == ST_ORIGIN)
  `BFT_ASSERT_NEXT(a_stall_holds, clk, rst, state == ST_SCAN && stall, $stable(glyph_sr) && $stable(col))
  `BFT_ASSERT_NEXT(a_scan_done, clk, rst, state == ST_SCAN && !stall && rest_zero, state == ST_ADV)
  `BFT_ASSERT_SAME(a_col_range, clk, rst, state == ST_SCAN, col <= 3'd4)

endmodule

FILE: rtl/core/bitmap_font_text_rasterizer.sv
// 5x7 bitmap font text rasteriser: one character in, up to 35 pixel squares out.
// after an item is accepted, the origin state latches the origin and the load state loads the
// scan; the scan takes one glyph bit per cycle while the output does not stall, up to the last
// set one (at most 35), then the advance state moves the cursor and idle takes the next item.
// a new item is taken only in idle; output stalls hold the scan.
// rst is synchronous: registers to defaults, cursor and text top to zero, no square pending.
module bitmap_font_text_rasterizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // char_code[7:0], origin_x[23:8], origin_y[39:24], string_length[47:40]
  input  logic [47:0] s_tdata,
  // first_of_string[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // rect_x[17:0], rect_y[34:18], rect_size[40:35], rect_color[72:41], zero pad[79:73]
  output logic [79:0] m_tdata,
  output logic        m_tlast
);
  import bft_pkg::*;

  cfg_t          cfg;
  alu_req_t      alu_req;
  logic [XW-1:0] alu_sum;

  bft_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bft_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  bft_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .alu_req  (alu_req),
    .alu_sum  (alu_sum)
  );

endmodule

FILE: tb/sv/tb_bitmap_font_text_rasterizer.sv
// self-checking testbench for the 5x7 bitmap font text rasteriser
// holds its own font table and scoreboard; needs bft_pkg and the rasteriser rtl
`timescale 1ns / 1ps

module tb_bitmap_font_text_rasterizer;
  import bft_pkg::*;

  localparam int GLYPH_COUNT = 48;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_REPORTS = 40;

  // character codes, first glyph in the top byte
  localparam logic [8*GLYPH_COUNT-1:0] FONT_CODES =
    " 0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-:.!+></,()";

  // seven 5-bit rows per glyph, top row first, leftmost pixel as msb
  localparam logic [35*GLYPH_COUNT-1:0] FONT_ROWS = {
    5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00,
    5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E,
    5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E,
    5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F,
    5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E,
    5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02,
    5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E,
    5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E,
    5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08,
    5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E,
    5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C,
    5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11,
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E,
    5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E,
    5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E,
    5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F,
    5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10,
    5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E,
    5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11,
    5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E,
    5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C,
    5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11,
    5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F,
    5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11,
    5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11,
    5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E,
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10,
    5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D,
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11,
    5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E,
    5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04,
    5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E,
    5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04,
    5'h11, 5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A,
    5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11,
    5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04,
    5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F,
    5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00,
    5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00,
    5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C,
    5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04,
    5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00,
    5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10,
    5'h01, 5'h02, 5'h04, 5'h08, 5'h04, 5'h02, 5'h01,
    5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00,
    5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h04, 5'h08,
    5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02,
    5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08
  };

  typedef struct {
    logic [XW-1:0]     x;
    logic [YW-1:0]     y;
    logic [SCALEW-1:0] size;
    logic [31:0]       color;
    logic              last;
  } square_t;

  class text_raster_scoreboard;
    logic [7:0]           text_size;
    logic                 center_mode;
    logic [31:0]          ink_color;
    logic signed [XW-1:0] cursor_x;
    logic signed [15:0]   text_top;
    square_t              pending_squares[$];
    int                   errors;

    function new();
      text_size   = 8'd7;
      center_mode = 1'b0;
      ink_color   = 32'hFFFF_FFFF;
      cursor_x    = '0;
      text_top    = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_TEXT_SIZE:   text_size = value[7:0];
        REG_CENTER_MODE: center_mode = value[0];
        REG_INK_COLOR:   ink_color = value;
        default: ;
      endcase
    endfunction

    // expected squares for one accepted character, cursor moved on afterwards
    function void note_char(logic [47:0] data, logic first);
      int sc, ox, len, total, g, n, k, row, col;
      logic [7:0] c;
      logic [34:0] bits;
      square_t sq;
      sc = text_size / 7;
      if (sc < 1) begin
        sc = 1;
      end
      if (first) begin
        ox = $signed(data[23:8]);
        len = data[47:40];
        text_top = data[39:24];
        if (center_mode) begin
          total = len * 6 * sc - sc;
          cursor_x = XW'(ox - total / 2);
        end else begin
          cursor_x = XW'(ox);
        end
      end
      c = data[7:0];
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
        c = c - CH_LOWER_A + CH_UPPER_A;
      end
      bits = '0;
      for (g = 0; g < GLYPH_COUNT; g++) begin
        if (FONT_CODES[8*(GLYPH_COUNT-1-g) +: 8] == c) begin
          bits = FONT_ROWS[35*(GLYPH_COUNT-1-g) +: 35];
        end
      end
      n = $countones(bits);
      k = 0;
      for (row = 0; row < 7; row++) begin
        for (col = 0; col < 5; col++) begin
          if (bits[34 - (row * 5 + col)]) begin
            k++;
            sq.x     = XW'(cursor_x + col * sc);
            sq.y     = YW'(text_top + row * sc);
            sq.size  = SCALEW'(sc);
            sq.color = ink_color;
            sq.last  = (k == n);
            pending_squares.push_back(sq);
          end
        end
      end
      cursor_x = XW'(cursor_x + 6 * sc);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        end
      end
    endfunction

    function void check_square(logic [79:0] data, logic last);
      square_t sq;
      if (pending_squares.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $error("square with nothing expected: tdata 0x%0h", data);
        end
      end else begin
        sq = pending_squares.pop_front();
        compare_field("rect_x", 32'(sq.x), 32'(data[17:0]));
        compare_field("rect_y", 32'(sq.y), 32'(data[34:18]));
        compare_field("rect_size", 32'(sq.size), 32'(data[40:35]));
        compare_field("rect_color", sq.color, data[72:41]);
        compare_field("last_of_char", 32'(sq.last), 32'(last));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // char_code, origin_x, origin_y, string_length
  logic        s_tuser;   // first_of_string
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // rect_x, rect_y, rect_size, rect_color, zero pad
  logic        m_tlast;   // last_of_char

  text_raster_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int cycles;

  bitmap_font_text_rasterizer dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // input noted before output checked, though the latency keeps them apart anyway
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (s_tvalid && s_tready) begin
        sb.note_char(s_tdata, s_tuser);
      end
      if (m_tvalid && m_tready) begin
        sb.check_square(m_tdata, m_tlast);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_pct == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_style(logic [7:0] size, logic center, logic [31:0] color);
    cfg_write(REG_TEXT_SIZE, {24'd0, size});
    cfg_write(REG_CENTER_MODE, {31'd0, center});
    cfg_write(REG_INK_COLOR, color);
  endtask

  task automatic send_char(logic [7:0] code, logic first, logic [15:0] ox,
                           logic [15:0] oy, logic [7:0] len);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {len, oy, ox, code};
    s_tuser  <= first;
    do begin
      @(posedge clk);
    end while (!s_tready);
    @(negedge clk);
  endtask

  // idle the sender until every square is out, then let the design settle
  task automatic wait_drained(int settle);
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending_squares.size() != 0) begin
      @(negedge clk);
    end
    repeat (settle) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return FONT_CODES[8*$urandom_range(GLYPH_COUNT-1) +: 8];
    end else if (r < 85) begin
      return CH_LOWER_A + 8'($urandom_range(25));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      return 16'h8000;
    end else if (r < 16) begin
      return 16'h7FFF;
    end else if (r < 50) begin
      return 16'($urandom_range(2047)) - 16'd1024;
    end
    return 16'($urandom_range(65535));
  endfunction

  // mostly well-formed strings; some with a wrong length field or stray first flags
  task automatic random_strings(int count);
    int sent, len, k;
    logic noisy;
    logic [7:0] len_field;
    logic [15:0] ox, oy;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 6);
      noisy = ($urandom_range(9) == 0);
      len_field = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'(len);
      ox = pick_coord();
      oy = pick_coord();
      for (k = 0; k < len; k++) begin
        send_char(pick_char(), noisy ? 1'($urandom_range(1)) : (k == 0), ox, oy,
                  len_field);
        if (noisy) begin
          ox = pick_coord();
          oy = pick_coord();
          len_field = 8'($urandom_range(255));
        end
        sent++;
      end
    end
  endtask

  initial begin
    int i, phase;
    logic [7:0] punct [11];
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    punct = '{"-", ":", ".", "!", "+", ">", "<", "/", ",", "(", ")"};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset style, no string started yet: cursor and top at zero
    send_char("A", 1'b0, 16'h1234, 16'h4321, 8'd9);
    send_char("a", 1'b0, 16'h0, 16'h0, 8'd0);
    send_char("z", 1'b0, 16'h0, 16'h0, 8'd0);
    send_char(" ", 1'b0, 16'h0, 16'h0, 8'd0);
    send_char(8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_char(8'h80, 1'b0, 16'h0, 16'h0, 8'd0);
    send_char(8'h00, 1'b0, 16'h0, 16'h0, 8'd0);
    send_char("0", 1'b0, 16'h0, 16'h0, 8'd0);
    send_char("9", 1'b0, 16'h0, 16'h0, 8'd0);
    send_char("8", 1'b1, 16'h7FFF, 16'h7FFF, 8'hFF);
    for (i = 0; i < 11; i++) begin
      send_char(punct[i], 1'b0, 16'h0, 16'h0, 8'd0);
    end
    wait_drained(SETTLE_CYCLES);

    // largest scale, centred, black ink; first character continues the old string
    set_style(8'd255, 1'b1, 32'h0000_0000);
    send_char("Q", 1'b0, 16'h0, 16'h0, 8'd0);
    send_char("M", 1'b1, 16'h8000, 16'h8000, 8'd0);
    send_char("W", 1'b1, 16'h7FFF, 16'h7FFF, 8'hFF);
    send_char("X", 1'b1, 16'h0, 16'h0, 8'd1);
    wait_drained(SETTLE_CYCLES);
    set_style(8'd6, 1'b1, 32'hA5A5_5A5A);
    send_char("K", 1'b1, 16'h8000, 16'h0010, 8'd2);
    wait_drained(SETTLE_CYCLES);
    cfg_write(REG_TEXT_SIZE, 32'd14);
    send_char("R", 1'b0, 16'h0, 16'h0, 8'd0);
    wait_drained(SETTLE_CYCLES);

    // march the cursor right from the top of the origin range with blanks
    set_style(8'd255, 1'b0, 32'h5A5A_A5A5);
    send_char("H", 1'b1, 16'h7FFF, 16'h0100, 8'd1);
    for (i = 0; i < 20; i++) begin
      send_char(" ", 1'b0, 16'h0, 16'h0, 8'd0);
    end
    for (i = 0; i < 6; i++) begin
      send_char("H", 1'b0, 16'h0, 16'h0, 8'd0);
    end
    wait_drained(SETTLE_CYCLES);

    for (phase = 0; phase < 4; phase++) begin
      set_style(($urandom_range(3) == 0) ? 8'($urandom_range(13)) : 8'($urandom_range(255)),
                1'($urandom_range(1)), $urandom);
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      random_strings(23);
      if (phase == 2) begin
        wait_drained(0);
      end
      random_strings(23);
      wait_drained(SETTLE_CYCLES);
      idle_pct = 0;
      stall_pct = 0;
    end

    if (sb.pending_squares.size() != 0) begin
      sb.errors += sb.pending_squares.size();
      $error("%0d squares never arrived", sb.pending_squares.size());
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
